[rtl/fee_pkg.sv]
`default_nettype none

package fee_pkg;

  // Geometry of the neighborhood and of the line buffer chain.
  localparam int WIN   = 5;
  localparam int LINES = 4;

  // Configuration register widths and reset values.
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int THRESH_W   = 8;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [THRESH_W-1:0] THRESH_RST = 8'd130;

  // Edge counter.
  localparam int CNT_W = 23;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef logic [7:0] pix_t;
  typedef pix_t [WIN-1:0] col_t;

  localparam pix_t PIX_MAX = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_e;

  // Controls shared by all line buffer cells.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic byp;
  } lc_ctl_t;

  // Controls of the window register.
  typedef struct packed {
    logic shift;
    logic zero;
    logic load;
  } win_ctl_t;

  function automatic pix_t pix_min(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  // A neighbor outside the image must not lower the minimum.
  function automatic pix_t pix_mask(pix_t v, logic ok);
    return ok ? v : PIX_MAX;
  endfunction

endpackage

`default_nettype wire

[rtl/fee_line_cell.sv]
`default_nettype none

module fee_line_cell import fee_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire lc_ctl_t                  ctl_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire pix_t                     din_i,
  output      pix_t                     dout_o
);

  pix_t mem_q [DEPTH];
  pix_t rd_q;

  // The old byte at a column moves on to the next cell while the byte from
  // the previous cell takes its place. A read of the column written in the
  // same cycle takes the new byte.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= din_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= ctl_i.byp ? din_i : mem_q[rd_addr_i];
    end
  end

  assign dout_o = rd_q;

endmodule

`default_nettype wire

[rtl/fee_window.sv]
`default_nettype none

module fee_window import fee_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire win_ctl_t       ctl_i,
  input  wire col_t           col_i,
  input  wire logic [WIN-1:0] rok_i,
  input  wire logic [WIN-1:0] cok_i,
  output      pix_t [2:0]     part_o,
  output      pix_t           centre_o
);

  // Stored column-major: win_q[column][row], column 4 is the newest.
  col_t [WIN-1:0] win_q;
  col_t [WIN-1:0] win_d;
  col_t [WIN-1:0] base;
  col_t [WIN-1:0] msk;
  pix_t [2:0]     part_d;
  pix_t [2:0]     part_q;
  pix_t           centre_q;

  always_comb begin
    base  = ctl_i.zero ? '0 : win_q;
    win_d = base;
    if (ctl_i.shift) begin
      for (int c = 0; c < WIN - 1; c++) begin
        win_d[c] = base[c+1];
      end
      win_d[WIN-1] = col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  always_comb begin
    for (int c = 0; c < WIN; c++) begin
      for (int r = 0; r < WIN; r++) begin
        msk[c][r] = pix_mask(win_q[c][r], rok_i[r] & cok_i[c]);
      end
    end
    // Diamond rows above, on and below the centre, in three groups of four.
    part_d[0] = pix_min(pix_min(msk[2][0], msk[1][1]), pix_min(msk[2][1], msk[3][1]));
    part_d[1] = pix_min(pix_min(msk[0][2], msk[1][2]), pix_min(msk[3][2], msk[4][2]));
    part_d[2] = pix_min(pix_min(msk[1][3], msk[2][3]), pix_min(msk[3][3], msk[2][4]));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      part_q   <= part_d;
      centre_q <= win_q[2][2];
    end
  end

  assign part_o   = part_q;
  assign centre_o = centre_q;

endmodule

`default_nettype wire

[rtl/fuzzy_erosion_edge_detector_top.sv]
// Streaming edge detector based on grey erosion over a 5x5 diamond.
// Pixels enter in raster order on the input channel (in_valid_i/in_stall_o),
// one item per clock unless stalled. An item of kind drain carries no pixel; it
// pushes the tail of the frame out once the last pixel has gone in, and a
// drain that arrives earlier is taken and dropped. Each result item on the
// output channel (out_valid_o/out_stall_i) belongs to the pixel that entered
// 2*width+2 items earlier, so that all in-image neighbors are present. The
// result goes through stages A, B and C to the output register once the item
// that completes it is taken. The rate of one item per cycle is set by the chain
// of four line buffer cells, each a single memory read and written once per item.
// When the receiver stalls, the output register holds its item and the three
// internal stages keep taking items until they are all full; only then is the
// input stalled. Configuration writes (cfg_valid_i/cfg_ready_o) are always
// taken and are meant to happen while no item is in flight.
// Reset clears the counters, the window and the edge count and loads the
// default geometry; the line buffers are not cleared and need no clearing pass,
// since no in-image position is read before it is written.
`default_nettype none

module fuzzy_erosion_edge_detector_top import fee_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic                  kind_i,
  input  wire logic [7:0]            pixel_value_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic                  edge_on_o,
  output      logic [CNT_W-1:0]      edge_total_o,
  output      logic                  frame_last_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_WIDTH);   // column address
  localparam int CW = AW + 2;              // column arithmetic
  localparam int FW = CW + 1;              // fill count, up to 2*width+2
  localparam int RW = $clog2(MAX_HEIGHT) + 2;

  // Configuration registers.
  logic [WIDTH_W-1:0]  cfg_width_q;
  logic [HEIGHT_W-1:0] cfg_height_q;
  logic [THRESH_W-1:0] cfg_thresh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RST;
      cfg_height_q <= HEIGHT_RST;
      cfg_thresh_q <= THRESH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  cfg_width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT: cfg_height_q <= cfg_data_i[HEIGHT_W-1:0];
        CFG_THRESH: cfg_thresh_q <= cfg_data_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero acts as one, oversize is clamped.
  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [FW-1:0] delay;

  always_comb begin
    if (cfg_width_q == '0) begin
      eff_w = CW'(1);
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      eff_h = RW'(1);
    end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(cfg_height_q);
    end
  end

  assign delay = {eff_w, 1'b0} + FW'(2);

  // Handshake enables, one per stage, from the output backwards.
  logic va_q, vb_q, vc_q, ov_q;
  logic en_a, en_b, en_c, en_out;

  assign en_out     = ~ov_q | ~out_stall_i;
  assign en_c       = ~vc_q | en_out;
  assign en_b       = ~vb_q | en_c;
  assign en_a       = ~va_q | en_b;
  assign in_stall_o = ~en_a;

  // Input side: position counters and result scheduling, all decided at the
  // moment an item is taken.
  logic [AW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [AW-1:0] out_col_q, out_col_d;
  logic [RW-1:0] out_row_q, out_row_d;
  logic [FW-1:0] fill_q, fill_d;

  logic          taking, drop, accept, enter, res, last;
  pix_t          value;
  logic [CW-1:0] col_inc, ocol_inc, ocol;
  logic [RW-1:0] orow_inc;
  logic [WIN-1:0] rok, cok;

  assign taking   = in_row_q < eff_h;
  assign drop     = (kind_e'(kind_i) == KIND_DRAIN) && taking;
  assign accept   = in_valid_i & en_a;
  assign enter    = accept & ~drop;
  assign value    = taking ? pixel_value_i : '0;
  assign res      = fill_q >= delay;
  assign col_inc  = CW'(in_col_q) + CW'(1);
  assign ocol     = CW'(out_col_q);
  assign ocol_inc = ocol + CW'(1);
  assign orow_inc = out_row_q + RW'(1);
  assign last     = (ocol_inc >= eff_w) && (orow_inc >= eff_h);

  // Which rows and columns of the window lie inside the image. After a
  // geometry change the output position may sit past the new edge, so the
  // rows and columns behind it are bounded on both sides.
  assign rok[0] = (out_row_q >= RW'(2)) && ((out_row_q - RW'(2)) < eff_h);
  assign rok[1] = (out_row_q >= RW'(1)) && ((out_row_q - RW'(1)) < eff_h);
  assign rok[2] = out_row_q < eff_h;
  assign rok[3] = orow_inc < eff_h;
  assign rok[4] = (out_row_q + RW'(2)) < eff_h;
  assign cok[0] = (ocol >= CW'(2)) && ((ocol - CW'(2)) < eff_w);
  assign cok[1] = (ocol >= CW'(1)) && ((ocol - CW'(1)) < eff_w);
  assign cok[2] = ocol < eff_w;
  assign cok[3] = ocol_inc < eff_w;
  assign cok[4] = (ocol + CW'(2)) < eff_w;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    fill_d    = fill_q;
    if (enter) begin
      if (col_inc >= eff_w) begin
        in_col_d = '0;
        if (taking) begin
          in_row_d = in_row_q + RW'(1);
        end
      end else begin
        in_col_d = AW'(col_inc);
      end
      if (!res) begin
        fill_d = fill_q + FW'(1);
      end else if (last) begin
        // The frame's final result: the next pixel starts a new frame.
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
        fill_d    = '0;
      end else if (ocol_inc >= eff_w) begin
        out_col_d = '0;
        out_row_d = orow_inc;
      end else begin
        out_col_d = AW'(ocol_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      fill_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      fill_q    <= fill_d;
    end
  end

  // Stage A: the line buffers are read at the item's column.
  logic [AW-1:0]  addr_a_q;
  pix_t           val_a_q;
  logic           res_a_q, last_a_q;
  logic [WIN-1:0] rok_a_q, cok_a_q;
  // Stage B: the window holds the item's neighborhood.
  logic           res_b_q, last_b_q;
  logic [WIN-1:0] rok_b_q, cok_b_q;
  // Stage C: partial minimums are registered.
  logic           last_c_q;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= enter;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
      if (en_c) begin
        vc_q <= vb_q & res_b_q;
      end
      if (en_out) begin
        ov_q <= vc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      addr_a_q <= in_col_q;
      val_a_q  <= value;
      res_a_q  <= res;
      last_a_q <= res & last;
      rok_a_q  <= rok;
      cok_a_q  <= cok;
    end
    if (en_b) begin
      res_b_q  <= res_a_q;
      last_b_q <= last_a_q;
      rok_b_q  <= rok_a_q;
      cok_b_q  <= cok_a_q;
    end
    if (en_c) begin
      last_c_q <= last_b_q;
    end
  end

  // Chain of line buffer cells: cell 0 holds the newest line.
  lc_ctl_t             lc_ctl;
  pix_t [LINES-1:0]    lc_din;
  pix_t [LINES-1:0]    lc_dout;

  assign lc_ctl.rd_en = enter;
  assign lc_ctl.wr_en = en_b & va_q;
  assign lc_ctl.byp   = lc_ctl.wr_en && (addr_a_q == in_col_q);

  for (genvar g = 0; g < LINES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign lc_din[g] = val_a_q;
    end else begin : g_link
      assign lc_din[g] = lc_dout[g-1];
    end
    fee_line_cell #(
      .DEPTH(MAX_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (lc_ctl),
      .rd_addr_i (in_col_q),
      .wr_addr_i (addr_a_q),
      .din_i     (lc_din[g]),
      .dout_o    (lc_dout[g])
    );
  end

  // New window column: oldest line at the top, the incoming pixel at the bottom.
  col_t new_col;

  always_comb begin
    new_col[WIN-1] = val_a_q;
    for (int r = 0; r < LINES; r++) begin
      new_col[r] = lc_dout[LINES-1-r];
    end
  end

  win_ctl_t   win_ctl;
  pix_t [2:0] part;
  pix_t       centre;

  assign win_ctl.shift = en_b & va_q;
  assign win_ctl.zero  = vb_q & last_b_q & en_c;
  assign win_ctl.load  = en_c;

  fee_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (win_ctl),
    .col_i    (new_col),
    .rok_i    (rok_b_q),
    .cok_i    (cok_b_q),
    .part_o   (part),
    .centre_o (centre)
  );

  // Output stage: erosion, fuzzy edge strength, threshold and running count.
  pix_t             ero, neg, strength;
  logic             is_edge;
  logic [CNT_W-1:0] count_q, total;
  logic             edge_on_q, frame_last_q;
  logic [CNT_W-1:0] total_q;

  assign ero      = pix_min(pix_min(part[0], part[1]), pix_min(part[2], centre));
  assign neg      = PIX_MAX - ero;
  assign strength = pix_min(neg, centre);
  assign is_edge  = strength > cfg_thresh_q;
  assign total    = (is_edge && (count_q != CNT_MAX)) ? count_q + CNT_W'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (en_out && vc_q) begin
      count_q <= last_c_q ? '0 : total;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && vc_q) begin
      edge_on_q    <= is_edge;
      total_q      <= total;
      frame_last_q <= last_c_q;
    end
  end

  assign out_valid_o  = ov_q;
  assign edge_on_o    = edge_on_q;
  assign edge_total_o = total_q;
  assign frame_last_o = frame_last_q;

endmodule

`default_nettype wire
